@@ design/jafc_pkg.sv @@
package jafc_pkg;

    localparam int AXES        = 4;
    localparam int TAPS        = 5;
    localparam int CAL_SAMPLES = 10;

    localparam int KIND_W   = 1;
    localparam int AXIS_W   = 2;
    localparam int LEVEL_W  = 12;
    localparam int STATUS_W = 2;
    localparam int BYTE_W   = 8;
    localparam int CSUM_W   = 16;

    localparam int LEVEL_MAX_I    = 4095;
    localparam int LEVEL_MID_I    = 2048;
    localparam int BYTE_MAX_I     = 255;
    localparam int SPREAD_RESET_I = 20;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX    = LEVEL_W'(LEVEL_MAX_I);
    localparam logic [LEVEL_W-1:0] LEVEL_MID    = LEVEL_W'(LEVEL_MID_I);
    localparam logic [LEVEL_W-1:0] SPREAD_RESET = LEVEL_W'(SPREAD_RESET_I);

    localparam int AX_IDX_W   = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int TAP_W      = $clog2(TAPS);
    localparam int RING_DEPTH = AXES * TAPS;
    localparam int ADDR_W     = $clog2(RING_DEPTH);
    localparam int SUM_W      = LEVEL_W + $clog2(TAPS);
    localparam int CNT_W      = $clog2(CAL_SAMPLES + 1);

    // Division by a constant: multiply by a rounded-up reciprocal, keep the upper bits.
    localparam int     MEAN_SHIFT  = SUM_W + $clog2(TAPS);
    localparam longint MEAN_K      = ((64'd1 << MEAN_SHIFT) + TAPS - 1) / TAPS;
    localparam int     MEAN_K_W    = $clog2(MEAN_K + 1);
    localparam int     MEAN_PROD_W = SUM_W + MEAN_K_W;

    localparam int     CAL_SHIFT  = CSUM_W + $clog2(CAL_SAMPLES);
    localparam longint CAL_K      = ((64'd1 << CAL_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES;
    localparam int     CAL_K_W    = $clog2(CAL_K + 1);
    localparam int     CAL_PROD_W = CSUM_W + CAL_K_W;

    localparam int     BYTE_SHIFT  = 2 * LEVEL_W;
    localparam longint BYTE_K      =
        ((longint'(BYTE_MAX_I) << BYTE_SHIFT) + LEVEL_MAX_I - 1) / LEVEL_MAX_I;
    localparam int     BYTE_K_W    = $clog2(BYTE_K + 1);
    localparam int     BYTE_PROD_W = LEVEL_W + BYTE_K_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_FILTER = 2'd0,
        OP_CAL    = 2'd1,
        OP_NONE   = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_FILTERED    = 2'd0,
        ST_CAL_ACCEPT  = 2'd1,
        ST_CAL_RESTART = 2'd2,
        ST_CAL_DONE    = 2'd3
    } status_t;

    typedef struct packed {
        op_t                 op;
        logic [AXIS_W-1:0]   axis;
        logic [LEVEL_W-1:0]  sample;
        logic                use_last;
    } cmd_t;

    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } queue_head_t;

endpackage

@@ design/jafc_if.sv @@
interface jafc_in_if import jafc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [AXIS_W-1:0]   axis;
    logic [LEVEL_W-1:0]  sample;
    logic                read_error;

    modport source (output valid, kind, axis, sample, read_error, input ready);
    modport sink   (input valid, kind, axis, sample, read_error, output ready);
endinterface

interface jafc_out_if import jafc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [AXIS_W-1:0]   axis_out;
    logic [LEVEL_W-1:0]  level;
    logic [BYTE_W-1:0]   byte_level;

    modport source (output valid, status, axis_out, level, byte_level, input ready);
    modport sink   (input valid, status, axis_out, level, byte_level, output ready);
endinterface

@@ design/jafc_ram.sv @@
module jafc_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 20
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/jafc_front.sv @@
module jafc_front import jafc_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    jafc_in_if.sink       samples,
    output queue_head_t   head,
    input  logic          pop
);

    cmd_t              entry_reg  [QUEUE_DEPTH];
    cmd_t              entry_next [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              accept;
    cmd_t              cmd_in;

    assign samples.ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign accept        = samples.valid && samples.ready;

    // classify the transaction
    always_comb
    begin
        cmd_in.axis     = samples.axis;
        cmd_in.sample   = samples.sample;
        cmd_in.use_last = 1'b0;
        if (int'(samples.axis) >= AXES)
        begin
            cmd_in.op = OP_NONE;
        end
        else if (samples.kind)
        begin
            cmd_in.op = OP_CAL;
        end
        else
        begin
            cmd_in.op       = OP_FILTER;
            cmd_in.use_last = samples.read_error;
        end
    end

    always_comb
    begin
        entry_next  = entry_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (accept)
        begin
            entry_next[wr_ptr_reg] = cmd_in;
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (accept && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !accept)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign head.valid = (count_reg != '0);
    assign head.cmd   = entry_reg[rd_ptr_reg];

`ifndef SYNTHESIS
    a_fill_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count lost an accepted transaction");
`endif

endmodule

@@ design/jafc_back.sv @@
module jafc_back import jafc_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [LEVEL_W-1:0]  cfg_wdata,
    input  queue_head_t         head,
    output logic                pop,
    jafc_out_if.source          results
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_LOAD   = 10'b0000000010,
        S_SUM    = 10'b0000000100,
        S_MDIV   = 10'b0000001000,
        S_MSCALE = 10'b0000010000,
        S_CAL    = 10'b0000100000,
        S_CDIV   = 10'b0001000000,
        S_CSCALE = 10'b0010000000,
        S_CFILL  = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;
    cmd_t   cur_reg, cur_next;

    logic [LEVEL_W-1:0] spread_limit_reg;

    logic [SUM_W-1:0]   ring_sum_reg   [AXES];
    logic [SUM_W-1:0]   ring_sum_next  [AXES];
    logic [TAP_W-1:0]   pos_reg        [AXES];
    logic [TAP_W-1:0]   pos_next       [AXES];
    logic [LEVEL_W-1:0] last_level_reg [AXES];
    logic [LEVEL_W-1:0] last_level_next[AXES];
    logic [LEVEL_W-1:0] fill_level_reg [AXES];
    logic [LEVEL_W-1:0] fill_level_next[AXES];
    logic [CNT_W-1:0]   cal_count_reg  [AXES];
    logic [CNT_W-1:0]   cal_count_next [AXES];
    logic [CSUM_W-1:0]  cal_sum_reg    [AXES];
    logic [CSUM_W-1:0]  cal_sum_next   [AXES];
    logic [LEVEL_W-1:0] cal_min_reg    [AXES];
    logic [LEVEL_W-1:0] cal_min_next   [AXES];
    logic [LEVEL_W-1:0] cal_max_reg    [AXES];
    logic [LEVEL_W-1:0] cal_max_next   [AXES];
    logic [RING_DEPTH-1:0] stale_reg, stale_next;

    logic [SUM_W-1:0]       acc_reg, acc_next;
    logic [CSUM_W-1:0]      csum_acc_reg, csum_acc_next;
    logic [MEAN_PROD_W-1:0] mean_prod_reg, mean_prod_next;
    logic [CAL_PROD_W-1:0]  cal_prod_reg, cal_prod_next;
    logic [BYTE_PROD_W-1:0] byte_prod_reg, byte_prod_next;
    logic [LEVEL_W-1:0]     level_reg, level_next;
    status_t                status_reg, status_next;

    logic                out_valid_reg;
    status_t             out_status_reg;
    logic [AXIS_W-1:0]   out_axis_reg;
    logic [LEVEL_W-1:0]  out_level_reg;
    logic [BYTE_W-1:0]   out_byte_reg;

    logic [AX_IDX_W-1:0] ax;
    logic [ADDR_W-1:0]   base;
    logic [ADDR_W-1:0]   addr;
    logic                ram_we;
    logic [LEVEL_W-1:0]  rdata;
    logic [LEVEL_W-1:0]  old_val;
    logic [LEVEL_W-1:0]  new_val;
    logic [SUM_W-1:0]    new_sum;
    logic [TAP_W-1:0]    pos_adv;
    logic [CNT_W-1:0]    cnt1;
    logic [CSUM_W-1:0]   csum1;
    logic [LEVEL_W-1:0]  min1;
    logic [LEVEL_W-1:0]  max1;
    logic [LEVEL_W-1:0]  spread;
    logic [LEVEL_W-1:0]  mean_level;
    logic [LEVEL_W-1:0]  center;
    logic                out_load;

    assign ax   = AX_IDX_W'(cur_reg.axis);
    assign base = ADDR_W'(int'(ax) * TAPS);
    assign addr = base + ADDR_W'(pos_reg[ax]);

    jafc_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr),
        .wdata (new_val),
        .raddr (addr),
        .rdata (rdata)
    );

    assign old_val    = stale_reg[addr] ? fill_level_reg[ax] : rdata;
    assign new_val    = cur_reg.use_last ? last_level_reg[ax] : cur_reg.sample;
    assign new_sum    = ring_sum_reg[ax] - SUM_W'(old_val) + SUM_W'(new_val);
    assign pos_adv    = (pos_reg[ax] == TAP_W'(TAPS - 1)) ? '0 : pos_reg[ax] + 1'b1;
    assign cnt1       = cal_count_reg[ax] + 1'b1;
    assign csum1      = cal_sum_reg[ax] + CSUM_W'(cur_reg.sample);
    assign min1       = (cur_reg.sample < cal_min_reg[ax]) ? cur_reg.sample : cal_min_reg[ax];
    assign max1       = (cur_reg.sample > cal_max_reg[ax]) ? cur_reg.sample : cal_max_reg[ax];
    assign spread     = max1 - min1;
    assign mean_level = mean_prod_reg[MEAN_SHIFT +: LEVEL_W];
    assign center     = cal_prod_reg[CAL_SHIFT +: LEVEL_W];
    assign out_load   = (state_reg == S_OUT) && (!out_valid_reg || results.ready);

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        ring_sum_next   = ring_sum_reg;
        pos_next        = pos_reg;
        last_level_next = last_level_reg;
        fill_level_next = fill_level_reg;
        cal_count_next  = cal_count_reg;
        cal_sum_next    = cal_sum_reg;
        cal_min_next    = cal_min_reg;
        cal_max_next    = cal_max_reg;
        stale_next      = stale_reg;
        acc_next        = acc_reg;
        csum_acc_next   = csum_acc_reg;
        mean_prod_next  = mean_prod_reg;
        cal_prod_next   = cal_prod_reg;
        byte_prod_next  = byte_prod_reg;
        level_next      = level_reg;
        status_next     = status_reg;
        ram_we          = 1'b0;
        pop             = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (head.valid)
                begin
                    pop      = 1'b1;
                    cur_next = head.cmd;
                    unique case (head.cmd.op)
                        OP_FILTER: state_next = S_LOAD;
                        OP_CAL:    state_next = S_CAL;
                        default:
                        begin
                            status_next    = ST_FILTERED;
                            level_next     = '0;
                            byte_prod_next = '0;
                            state_next     = S_OUT;
                        end
                    endcase
                end
            end
            S_LOAD:
            begin
                state_next = S_SUM;
            end
            S_SUM:
            begin
                ram_we              = 1'b1;
                stale_next[addr]    = 1'b0;
                ring_sum_next[ax]   = new_sum;
                pos_next[ax]        = pos_adv;
                acc_next            = new_sum;
                state_next          = S_MDIV;
            end
            S_MDIV:
            begin
                mean_prod_next = MEAN_PROD_W'(acc_reg) * MEAN_PROD_W'(MEAN_K);
                state_next     = S_MSCALE;
            end
            S_MSCALE:
            begin
                level_next          = mean_level;
                last_level_next[ax] = mean_level;
                byte_prod_next      = BYTE_PROD_W'(mean_level) * BYTE_PROD_W'(BYTE_K);
                status_next         = ST_FILTERED;
                state_next          = S_OUT;
            end
            S_CAL:
            begin
                level_next     = '0;
                byte_prod_next = '0;
                if (cnt1 >= CNT_W'(CAL_SAMPLES))
                begin
                    cal_count_next[ax] = '0;
                    cal_sum_next[ax]   = '0;
                    cal_min_next[ax]   = LEVEL_MAX;
                    cal_max_next[ax]   = '0;
                    if (spread > spread_limit_reg)
                    begin
                        status_next = ST_CAL_RESTART;
                        state_next  = S_OUT;
                    end
                    else
                    begin
                        csum_acc_next = csum1;
                        state_next    = S_CDIV;
                    end
                end
                else
                begin
                    cal_count_next[ax] = cnt1;
                    cal_sum_next[ax]   = csum1;
                    cal_min_next[ax]   = min1;
                    cal_max_next[ax]   = max1;
                    status_next        = ST_CAL_ACCEPT;
                    state_next         = S_OUT;
                end
            end
            S_CDIV:
            begin
                cal_prod_next = CAL_PROD_W'(csum_acc_reg) * CAL_PROD_W'(CAL_K);
                state_next    = S_CSCALE;
            end
            S_CSCALE:
            begin
                level_next     = center;
                byte_prod_next = BYTE_PROD_W'(center) * BYTE_PROD_W'(BYTE_K);
                status_next    = ST_CAL_DONE;
                state_next     = S_CFILL;
            end
            S_CFILL:
            begin
                fill_level_next[ax] = level_reg;
                ring_sum_next[ax]   = SUM_W'(int'(level_reg) * TAPS);
                for (int i = 0; i < TAPS; i++)
                begin
                    stale_next[base + ADDR_W'(i)] = 1'b1;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cur_reg          <= '{op: OP_NONE, default: '0};
            spread_limit_reg <= SPREAD_RESET;
            stale_reg        <= '1;
            out_valid_reg    <= 1'b0;
            for (int a = 0; a < AXES; a++)
            begin
                ring_sum_reg[a]   <= '0;
                pos_reg[a]        <= '0;
                last_level_reg[a] <= LEVEL_MID;
                fill_level_reg[a] <= '0;
                cal_count_reg[a]  <= '0;
                cal_sum_reg[a]    <= '0;
                cal_min_reg[a]    <= LEVEL_MAX;
                cal_max_reg[a]    <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            stale_reg      <= stale_next;
            ring_sum_reg   <= ring_sum_next;
            pos_reg        <= pos_next;
            last_level_reg <= last_level_next;
            fill_level_reg <= fill_level_next;
            cal_count_reg  <= cal_count_next;
            cal_sum_reg    <= cal_sum_next;
            cal_min_reg    <= cal_min_next;
            cal_max_reg    <= cal_max_next;
            if (cfg_we)
            begin
                spread_limit_reg <= cfg_wdata;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        csum_acc_reg  <= csum_acc_next;
        mean_prod_reg <= mean_prod_next;
        cal_prod_reg  <= cal_prod_next;
        byte_prod_reg <= byte_prod_next;
        level_reg     <= level_next;
        status_reg    <= status_next;
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_axis_reg   <= cur_reg.axis;
            out_level_reg  <= level_reg;
            out_byte_reg   <= byte_prod_reg[BYTE_SHIFT +: BYTE_W];
        end
    end

    assign results.valid      = out_valid_reg;
    assign results.status     = out_status_reg;
    assign results.axis_out   = out_axis_reg;
    assign results.level      = out_level_reg;
    assign results.byte_level = out_byte_reg;

`ifndef SYNTHESIS
    a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ring_sum_reg[ax] <= SUM_W'(TAPS * LEVEL_MAX_I))
        else $error("running ring sum out of range");

    a_cal_order: assert property (@(posedge clk) disable iff (!rst_n)
        cal_count_reg[ax] != '0 |-> cal_min_reg[ax] <= cal_max_reg[ax])
        else $error("calibration min above max during a run");

    a_pos_moves: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SUM |=> pos_reg[$past(ax)] != $past(pos_reg[ax]))
        else $error("ring position did not advance after a filtered sample");
`endif

endmodule

@@ design/joystick_axis_filter_with_calibration_unit.sv @@
// Four-axis joystick conditioner: 5-tap moving average per axis plus rest calibration.
// Channels: samples (valid/ready, sink) carries kind, axis, sample, read_error;
// results (valid/ready, source) carries status, axis_out, level, byte_level.
// Exactly one result per accepted transaction, in acceptance order.
// Configuration: cfg_we writes cfg_wdata into the spread limit (reset 20);
// write only while no transaction is in flight.
// Processing: a filtered sample passes through the ring read, the running-sum
// update and the two reciprocal multiplies; a completed calibration run through
// its two reciprocal multiplies and the ring refill. An axis outside the
// configured range goes straight to the result register. The back end holds
// one transaction at a time and takes no new one before that result is loaded.
// A two-entry queue in front keeps accepting while the back end works.
// Reset: rings read as zero, last output 2048 per axis, calibration runs
// cleared, queue and result register empty.
// Receiver stall: the result register holds; the back end waits, the queue
// fills, then samples.ready drops.
module joystick_axis_filter_with_calibration_unit import jafc_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [LEVEL_W-1:0]  cfg_wdata,
    jafc_in_if.sink             samples,
    jafc_out_if.source          results
);

    queue_head_t head;
    logic        pop;

    jafc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples),
        .head    (head),
        .pop     (pop)
    );

    jafc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .head      (head),
        .pop       (pop),
        .results   (results)
    );

endmodule
